/* rtl/ptag_pkg.sv */
// Shared types and constants of the permuted tensor address generator.
package ptag_pkg;

   // Fixed shape of the block
   localparam int unsigned NUM_DIMS    = 4;
   localparam int unsigned MAX_RANK    = 4;
   localparam int unsigned INDEX_BITS  = 16;
   localparam int unsigned OFFSET_BITS = 32;
   localparam int unsigned SIZE_BITS   = 16;
   localparam int unsigned RANK_BITS   = 3;
   localparam int unsigned POS_BITS    = 2;
   localparam int unsigned LAYOUT_BITS = NUM_DIMS * POS_BITS;
   localparam int unsigned CSR_IDX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS = 16;

   typedef logic [RANK_BITS-1:0]     rank_type;
   typedef logic [POS_BITS-1:0]      pos_type;
   typedef logic [SIZE_BITS-1:0]     size_type;
   typedef logic [INDEX_BITS-1:0]    index_type;
   typedef logic [OFFSET_BITS-1:0]   offset_type;
   typedef logic [LAYOUT_BITS-1:0]   layout_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_RANK   = 3'd0,
      CSR_DIM0   = 3'd1,
      CSR_DIM1   = 3'd2,
      CSR_DIM2   = 3'd3,
      CSR_DIM3   = 3'd4,
      CSR_LAYOUT = 3'd5
   } csr_index_type;

   // Reset values of the registers
   localparam rank_type   RANK_RESET   = 3'd4;
   localparam size_type   SIZE_RESET   = 16'd1;
   localparam layout_type LAYOUT_RESET = 8'd228;

   // Configuration as seen by the datapath; rank is already clamped to 1..MAX_RANK
   typedef struct packed {
      rank_type                  rank;
      size_type [NUM_DIMS-1:0]   size;
      layout_type                layout;
   } cfg_type;

   // Stride modulo 2^OFFSET_BITS plus a flag for an exact value beyond range
   typedef struct packed {
      logic       big;
      offset_type v;
   } stride_type;

   // Stride stage to accumulate stage transfer
   typedef struct packed {
      logic                       valid;
      logic                       bad;
      pos_type    [NUM_DIMS-1:0]  pos;
      index_type  [NUM_DIMS-1:0]  idx;
      stride_type [NUM_DIMS-1:0]  stride;
   } strd_type;

endpackage

/* rtl/ptag_csr.sv */
// Configuration registers of the permuted tensor address generator.
module ptag_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptag_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  ptag_pkg::csr_data_type               csr_wdata,
   output ptag_pkg::cfg_type                    cfg
);

   ptag_pkg::rank_type                        rank_ff;
   ptag_pkg::rank_type                        rank_in;
   ptag_pkg::size_type [ptag_pkg::NUM_DIMS-1:0] size_ff;
   ptag_pkg::layout_type                      layout_ff;

   // Always take a write
   assign csr_ready = 1'b1;

   // Clamp rank to the supported range
   always_comb begin
      rank_in = csr_wdata[ptag_pkg::RANK_BITS-1:0];
      if (rank_in == '0) begin
         rank_in = ptag_pkg::rank_type'(1);
      end else if (rank_in > ptag_pkg::rank_type'(ptag_pkg::MAX_RANK)) begin
         rank_in = ptag_pkg::rank_type'(ptag_pkg::MAX_RANK);
      end
   end

   // Decode the write transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff   <= ptag_pkg::RANK_RESET;
         size_ff   <= {ptag_pkg::NUM_DIMS{ptag_pkg::SIZE_RESET}};
         layout_ff <= ptag_pkg::LAYOUT_RESET;
      end else if (csr_valid) begin
         unique case (ptag_pkg::csr_index_type'(csr_index))
            ptag_pkg::CSR_RANK:   rank_ff    <= rank_in;
            ptag_pkg::CSR_DIM0:   size_ff[0] <= csr_wdata[ptag_pkg::SIZE_BITS-1:0];
            ptag_pkg::CSR_DIM1:   size_ff[1] <= csr_wdata[ptag_pkg::SIZE_BITS-1:0];
            ptag_pkg::CSR_DIM2:   size_ff[2] <= csr_wdata[ptag_pkg::SIZE_BITS-1:0];
            ptag_pkg::CSR_DIM3:   size_ff[3] <= csr_wdata[ptag_pkg::SIZE_BITS-1:0];
            ptag_pkg::CSR_LAYOUT: layout_ff  <= csr_wdata[ptag_pkg::LAYOUT_BITS-1:0];
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   assign cfg.rank   = rank_ff;
   assign cfg.size   = size_ff;
   assign cfg.layout = layout_ff;

endmodule

/* rtl/ptag_stride.sv */
// Layout decode and physical stride stages (pipeline stages one and two).
module ptag_stride (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  ptag_pkg::index_type [ptag_pkg::NUM_DIMS-1:0] in_idx,
   input  ptag_pkg::cfg_type                          cfg,
   output ptag_pkg::strd_type                         strd
);

   localparam int unsigned N = ptag_pkg::NUM_DIMS;

   typedef logic [2*ptag_pkg::SIZE_BITS-1:0] prod2_type;
   typedef logic [3*ptag_pkg::SIZE_BITS-1:0] prod3_type;

   // stage one combinational
   ptag_pkg::pos_type   [N-1:0] pos;
   ptag_pkg::size_type  [N-1:0] fac;
   ptag_pkg::index_type [N-1:0] idx_m;
   logic                [N-1:0] seen;
   logic                        bad;
   prod2_type                   m23;

   // stage one registers
   logic                        s1_valid_ff;
   logic                        s1_bad_ff;
   ptag_pkg::pos_type   [N-1:0] s1_pos_ff;
   ptag_pkg::index_type [N-1:0] s1_idx_ff;
   ptag_pkg::size_type          s1_f1_ff;
   ptag_pkg::size_type          s1_f3_ff;
   prod2_type                   s1_m23_ff;

   // stage two
   prod3_type                      m123;
   ptag_pkg::stride_type [N-1:0]   stride_in;
   ptag_pkg::strd_type             s2_ff;

   // Decode the layout map, check it, and gather sizes by physical slot
   always_comb begin
      seen = '0;
      bad  = 1'b0;
      for (int i = 0; i < N; i++) begin
         pos[i] = cfg.layout[i*ptag_pkg::POS_BITS +: ptag_pkg::POS_BITS];
      end
      for (int i = 0; i < N; i++) begin
         if (ptag_pkg::rank_type'(i) < cfg.rank) begin
            if ({1'b0, pos[i]} >= cfg.rank || seen[pos[i]]) begin
               bad = 1'b1;
            end
            seen[pos[i]] = 1'b1;
         end
      end
      for (int q = 0; q < N; q++) begin
         if (ptag_pkg::rank_type'(q) < cfg.rank) begin
            fac[q] = '0;
            for (int k = 0; k < N; k++) begin
               if (ptag_pkg::rank_type'(k) < cfg.rank && pos[k] == ptag_pkg::pos_type'(q)) begin
                  fac[q] = fac[q] | cfg.size[k];
               end
            end
         end else begin
            fac[q] = ptag_pkg::size_type'(1);
         end
      end
      for (int i = 0; i < N; i++) begin
         idx_m[i] = (ptag_pkg::rank_type'(i) < cfg.rank) ? in_idx[i] : '0;
      end
      m23 = prod2_type'(fac[2]) * prod2_type'(fac[3]);
   end

   // Stage one registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_bad_ff <= bad;
      s1_pos_ff <= pos;
      s1_idx_ff <= idx_m;
      s1_f1_ff  <= fac[1];
      s1_f3_ff  <= fac[3];
      s1_m23_ff <= m23;
   end

   // Finish the stride chain; slot three always has stride one
   always_comb begin
      m123 = prod3_type'(s1_m23_ff) * prod3_type'(s1_f1_ff);
      stride_in[0].v   = m123[ptag_pkg::OFFSET_BITS-1:0];
      stride_in[0].big = |m123[3*ptag_pkg::SIZE_BITS-1:ptag_pkg::OFFSET_BITS];
      stride_in[1].v   = ptag_pkg::offset_type'(s1_m23_ff);
      stride_in[1].big = 1'b0;
      stride_in[2].v   = ptag_pkg::offset_type'(s1_f3_ff);
      stride_in[2].big = 1'b0;
      stride_in[3].v   = ptag_pkg::offset_type'(1);
      stride_in[3].big = 1'b0;
   end

   // Stage two registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= s1_valid_ff;
      end
      s2_ff.bad    <= s1_bad_ff;
      s2_ff.pos    <= s1_pos_ff;
      s2_ff.idx    <= s1_idx_ff;
      s2_ff.stride <= stride_in;
   end

   assign strd = s2_ff;

endmodule

/* rtl/ptag_accum.sv */
// Index times stride lanes and offset sum (pipeline stages three and four).
module ptag_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  ptag_pkg::strd_type       strd,
   output logic                     rsp_valid,
   output ptag_pkg::offset_type     rsp_offset,
   output logic                     rsp_overflowed,
   output logic                     rsp_bad_layout
);

   localparam int unsigned N = ptag_pkg::NUM_DIMS;
   localparam int unsigned W = ptag_pkg::OFFSET_BITS + ptag_pkg::INDEX_BITS;

   typedef logic [W-1:0]                        term_wide_type;
   typedef logic [ptag_pkg::OFFSET_BITS+1:0]    sum_type;

   ptag_pkg::stride_type [N-1:0] sel;
   term_wide_type        [N-1:0] term;
   ptag_pkg::offset_type [N-1:0] tv_in;
   logic                 [N-1:0] tbig_in;

   logic                         s3_valid_ff;
   logic                         s3_bad_ff;
   ptag_pkg::offset_type [N-1:0] s3_tv_ff;
   logic                 [N-1:0] s3_tbig_ff;

   sum_type                      sum;
   logic                         over;

   logic                         rsp_valid_ff;
   ptag_pkg::offset_type         offset_ff;
   logic                         over_ff;
   logic                         bad_ff;

   // Pick each lane's stride by its physical slot and scale by the index
   always_comb begin
      for (int i = 0; i < N; i++) begin
         sel[i]     = strd.stride[strd.pos[i]];
         term[i]    = term_wide_type'(sel[i].v) * term_wide_type'(strd.idx[i]);
         tv_in[i]   = term[i][ptag_pkg::OFFSET_BITS-1:0];
         tbig_in[i] = (sel[i].big && strd.idx[i] != '0)
                    || (term[i][W-1:ptag_pkg::OFFSET_BITS] != '0);
      end
   end

   // Stage three registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= strd.valid;
      end
      s3_bad_ff  <= strd.bad;
      s3_tv_ff   <= tv_in;
      s3_tbig_ff <= tbig_in;
   end

   // Add the lanes; any carry out of the offset range or a big term flags overflow
   always_comb begin
      sum = '0;
      for (int i = 0; i < N; i++) begin
         sum = sum + sum_type'(s3_tv_ff[i]);
      end
      over = (|s3_tbig_ff) || (sum[ptag_pkg::OFFSET_BITS+1:ptag_pkg::OFFSET_BITS] != '0);
   end

   // Output registers; a bad layout forces a zero offset and no overflow
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
      offset_ff <= s3_bad_ff ? '0 : sum[ptag_pkg::OFFSET_BITS-1:0];
      over_ff   <= s3_bad_ff ? 1'b0 : over;
      bad_ff    <= s3_bad_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_offset     = offset_ff;
   assign rsp_overflowed = over_ff;
   assign rsp_bad_layout = bad_ff;

endmodule

/* rtl/permuted_tensor_address_gen_top.sv */
// Top level of the permuted tensor address generator.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | req_idx0 .. req_idx3
//  response  | rsp_valid (strobe)   | rsp_offset, rsp_overflowed, rsp_bad_layout
//  config    | csr_valid / csr_ready| csr_index, csr_wdata
//
// A request taken at one edge shows its response after the four register stages, for one cycle.
// One request per cycle: the four register stages (layout decode and first size
// product, stride chain multiply, index times stride, lane sum) all advance each cycle.
// busy never rises; the response side cannot stall, so nothing is held back.
// Synchronous reset clears the valid bits of every stage and restores the registers
// to rank 4, sizes 1 and the identity layout.
module permuted_tensor_address_gen_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  ptag_pkg::index_type                  req_idx0,
   input  ptag_pkg::index_type                  req_idx1,
   input  ptag_pkg::index_type                  req_idx2,
   input  ptag_pkg::index_type                  req_idx3,
   output logic                                 rsp_valid,
   output ptag_pkg::offset_type                 rsp_offset,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_bad_layout,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptag_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  ptag_pkg::csr_data_type               csr_wdata
);

   ptag_pkg::cfg_type                              cfg;
   ptag_pkg::strd_type                             strd;
   ptag_pkg::index_type [ptag_pkg::NUM_DIMS-1:0]   in_idx;
   logic                                           in_valid;

   // The pipeline takes a transaction every cycle
   assign busy     = 1'b0;
   assign in_valid = start && !busy;

   assign in_idx[0] = req_idx0;
   assign in_idx[1] = req_idx1;
   assign in_idx[2] = req_idx2;
   assign in_idx[3] = req_idx3;

   ptag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ptag_stride u_stride (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_idx   (in_idx),
      .cfg      (cfg),
      .strd     (strd)
   );

   ptag_accum u_accum (
      .clock          (clock),
      .reset          (reset),
      .strd           (strd),
      .rsp_valid      (rsp_valid),
      .rsp_offset     (rsp_offset),
      .rsp_overflowed (rsp_overflowed),
      .rsp_bad_layout (rsp_bad_layout)
   );

endmodule

/* rtl/ptag_checker.sv */
// Port-level checks of the permuted tensor address generator, bound to the top level.
module ptag_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input ptag_pkg::offset_type                 rsp_offset,
   input logic                                 rsp_overflowed,
   input logic                                 rsp_bad_layout
);

   // Every accepted transaction yields a response
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted request produced no response");

   // No response appears without an earlier accepted request
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("response without matching request");

   // A bad layout gives zero offset and no overflow
   a_bad_layout: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_layout) |-> (rsp_offset == '0 && !rsp_overflowed))
      else $error("bad layout response carries offset or overflow");

   // Reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response strobe right after reset");

endmodule

bind permuted_tensor_address_gen_top ptag_checker u_ptag_checker (.*);

/* test/ptag_offset_checker.sv */
// Offset checker: predicts each flat offset from the mirrored registers and compares responses.
`timescale 1ns / 1ps

module ptag_offset_checker
   import ptag_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  index_type               req_idx0,
   input  index_type               req_idx1,
   input  index_type               req_idx2,
   input  index_type               req_idx3,
   input  logic                    rsp_valid,
   input  offset_type              rsp_offset,
   input  logic                    rsp_overflowed,
   input  logic                    rsp_bad_layout,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  csr_data_type            csr_wdata,
   output int                      mismatch_count,
   output int                      pending_count,
   output int                      checked_count,
   output int                      wrapped_count,
   output int                      rejected_count
);

   localparam logic [63:0] OFF_LIMIT = 64'h0000_0000_FFFF_FFFF;
   localparam int          REPORT_MAX = 10;

   typedef struct {
      offset_type offset;
      logic       overflowed;
      logic       bad_layout;
   } offset_result_type;

   // Mirror of the register file
   rank_type                cfg_rank;
   size_type [NUM_DIMS-1:0] cfg_size;
   layout_type              cfg_layout;

   offset_result_type expected_offsets[$];
   offset_result_type want;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
      wrapped_count  = 0;
      rejected_count = 0;
   end

   // Multiply a tracked value by a factor, keeping exact-zero and beyond-range flags
   function automatic void widen_mul(inout logic [63:0] v, inout logic is_zero,
                                     inout logic is_big, input logic [63:0] factor);
      if (is_zero || factor == 64'd0) begin
         is_zero = 1'b1;
         is_big  = 1'b0;
      end else if (!is_big) begin
         is_big = (v > OFF_LIMIT / factor);
      end
      v = v * factor;
   endfunction

   // Work out the flat offset of one coordinate under the current registers
   function automatic offset_result_type predict_offset(index_type [NUM_DIMS-1:0] coord);
      offset_result_type res;
      int             used;
      pos_type        pos [NUM_DIMS];
      logic [3:0]     seen;
      logic           bad;
      logic           over;
      logic [63:0]    sum;
      logic [63:0]    sv;
      logic           s_zero;
      logic           s_big;
      int             i;
      int             k;
      used = (cfg_rank == 0) ? 1 : (cfg_rank > MAX_RANK) ? MAX_RANK : int'(cfg_rank);
      seen = '0;
      bad  = 1'b0;
      over = 1'b0;
      sum  = '0;
      for (i = 0; i < used; i++) begin
         pos[i] = cfg_layout[2*i +: 2];
         if (pos[i] >= used || seen[pos[i]]) bad = 1'b1;
         seen[pos[i]] = 1'b1;
      end
      if (bad) begin
         res.offset     = '0;
         res.overflowed = 1'b0;
         res.bad_layout = 1'b1;
         return res;
      end
      for (i = 0; i < used; i++) begin
         sv     = 64'd1;
         s_zero = 1'b0;
         s_big  = 1'b0;
         // stride is the product of sizes at later physical positions
         for (k = 0; k < used; k++) begin
            if (pos[k] > pos[i]) widen_mul(sv, s_zero, s_big, 64'(cfg_size[k]));
         end
         widen_mul(sv, s_zero, s_big, 64'(coord[i]));
         if (!s_zero) begin
            if (s_big) over = 1'b1;
            else if (sum > OFF_LIMIT - sv) over = 1'b1;
         end
         sum = sum + sv;
      end
      res.offset     = sum[OFFSET_BITS-1:0];
      res.overflowed = over;
      res.bad_layout = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_rank   = RANK_RESET;
         cfg_size   = {NUM_DIMS{SIZE_RESET}};
         cfg_layout = LAYOUT_RESET;
         expected_offsets.delete();
      end else begin
         // Compare a response with the oldest expected transaction
         if (rsp_valid) begin
            if (expected_offsets.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected response: offset %h overflowed %b bad_layout %b",
                           rsp_offset, rsp_overflowed, rsp_bad_layout);
            end else begin
               want = expected_offsets.pop_front();
               checked_count++;
               if (want.overflowed) wrapped_count++;
               if (want.bad_layout) rejected_count++;
               if (rsp_offset !== want.offset || rsp_overflowed !== want.overflowed ||
                   rsp_bad_layout !== want.bad_layout) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("mismatch on response %0d: expected %h/%b/%b, got %h/%b/%b",
                              checked_count, want.offset, want.overflowed, want.bad_layout,
                              rsp_offset, rsp_overflowed, rsp_bad_layout);
               end
            end
         end
         // Predict each accepted request transaction and append it at the tail
         if (start && !busy)
            expected_offsets.insert(expected_offsets.size(),
                                    predict_offset({req_idx3, req_idx2, req_idx1, req_idx0}));
         // Track register writes; unmapped indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RANK:   cfg_rank   = csr_wdata[RANK_BITS-1:0];
               CSR_DIM0:   cfg_size[0] = csr_wdata;
               CSR_DIM1:   cfg_size[1] = csr_wdata;
               CSR_DIM2:   cfg_size[2] = csr_wdata;
               CSR_DIM3:   cfg_size[3] = csr_wdata;
               CSR_LAYOUT: cfg_layout = csr_wdata[LAYOUT_BITS-1:0];
               default:    ;
            endcase
         end
      end
      pending_count = expected_offsets.size();
   end

endmodule

/* test/permuted_tensor_address_gen_top_test.sv */
// Testbench top: drives coordinates and register writes into the address generator.
`timescale 1ns / 1ps

module permuted_tensor_address_gen_top_test;
   import ptag_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;
   localparam int NUM_PHASES   = 25;

   // Indexes with no register behind them
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_A = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED_B = 3'd7;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   index_type               req_idx0;
   index_type               req_idx1;
   index_type               req_idx2;
   index_type               req_idx3;
   logic                    rsp_valid;
   offset_type              rsp_offset;
   logic                    rsp_overflowed;
   logic                    rsp_bad_layout;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index;
   csr_data_type            csr_wdata;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int wrapped_count;
   int rejected_count;
   int coord_count;
   int settings_count;
   int quiet_cycles;
   bit steady;

   permuted_tensor_address_gen_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_idx0       (req_idx0),
      .req_idx1       (req_idx1),
      .req_idx2       (req_idx2),
      .req_idx3       (req_idx3),
      .rsp_valid      (rsp_valid),
      .rsp_offset     (rsp_offset),
      .rsp_overflowed (rsp_overflowed),
      .rsp_bad_layout (rsp_bad_layout),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ptag_offset_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_idx0       (req_idx0),
      .req_idx1       (req_idx1),
      .req_idx2       (req_idx2),
      .req_idx3       (req_idx3),
      .rsp_valid      (rsp_valid),
      .rsp_offset     (rsp_offset),
      .rsp_overflowed (rsp_overflowed),
      .rsp_bad_layout (rsp_bad_layout),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .wrapped_count  (wrapped_count),
      .rejected_count (rejected_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // End the run when no transaction of any kind moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_count);
         $display("FAIL permuted_tensor_address_gen_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Number of idle cycles to insert before the next transaction
   function automatic int gap_cycles();
      int n;
      n = 0;
      while (!steady && $urandom_range(99) < 9) n++;
      return n;
   endfunction

   // Offer one coordinate and hold it until taken
   task automatic send_coord(input index_type i0, input index_type i1,
                             input index_type i2, input index_type i3);
      int n;
      n = gap_cycles();
      if (n != 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
      start    <= 1'b1;
      req_idx0 <= i0;
      req_idx1 <= i1;
      req_idx2 <= i2;
      req_idx3 <= i3;
      do @(posedge clock); while (busy);
      @(negedge clock);
      coord_count++;
   endtask

   // Write one register and hold the write until taken
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input csr_data_type data);
      int n;
      n = gap_cycles();
      if (n != 0) begin
         csr_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Drop start and wait until every response has come back
   task automatic settle();
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Load a full register set while the block is idle
   task automatic apply_config(input rank_type r, input size_type [NUM_DIMS-1:0] sz,
                               input layout_type lay, input bit spare);
      csr_data_type rank_word;
      csr_data_type layout_word;
      rank_word   = csr_data_type'($urandom);
      layout_word = csr_data_type'($urandom);
      rank_word[RANK_BITS-1:0]     = r;
      layout_word[LAYOUT_BITS-1:0] = lay;
      settle();
      write_reg(CSR_RANK, rank_word);
      write_reg(CSR_DIM0, sz[0]);
      write_reg(CSR_DIM1, sz[1]);
      write_reg(CSR_DIM2, sz[2]);
      write_reg(CSR_DIM3, sz[3]);
      write_reg(CSR_LAYOUT, layout_word);
      if (spare) begin
         write_reg(CSR_UNMAPPED_A, csr_data_type'($urandom));
         write_reg(CSR_UNMAPPED_B, csr_data_type'($urandom));
      end
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Layout map that places the used dimensions on a shuffled set of positions
   function automatic layout_type make_layout(input int used);
      layout_type lay;
      pos_type    slot [NUM_DIMS];
      pos_type    tmp;
      int         j;
      int         k;
      lay = layout_type'($urandom);
      for (j = 0; j < NUM_DIMS; j++) slot[j] = pos_type'(j);
      for (j = used - 1; j > 0; j--) begin
         k       = $urandom_range(0, j);
         tmp     = slot[j];
         slot[j] = slot[k];
         slot[k] = tmp;
      end
      for (j = 0; j < used; j++) lay[2*j +: 2] = slot[j];
      return lay;
   endfunction

   // Coordinate mostly inside its dimension, sometimes anywhere in the field
   function automatic index_type pick_index(input size_type s, input bit wild);
      if (wild || s == 0) return index_type'($urandom);
      return index_type'($urandom_range(0, s - 1));
   endfunction

   initial begin
      int                      phase;
      int                      n_items;
      int                      j;
      int                      d;
      int                      used;
      rank_type                r;
      size_type [NUM_DIMS-1:0] sz;
      layout_type              lay;
      bit                      wild;

      reset          = 1'b1;
      start          = 1'b0;
      req_idx0       = '0;
      req_idx1       = '0;
      req_idx2       = '0;
      req_idx3       = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_RANK;
      csr_wdata      = '0;
      quiet_cycles   = 0;
      coord_count    = 0;
      settings_count = 1;
      steady         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: identity layout, unit sizes
      send_coord(16'd0, 16'd0, 16'd0, 16'd0);
      send_coord(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_coord(16'd1, 16'd2, 16'd3, 16'd4);

      // Largest sizes: huge strides, overflow only where the index is nonzero
      apply_config(3'd4, {NUM_DIMS{16'hFFFF}}, LAYOUT_RESET, 1'b0);
      send_coord(16'd0, 16'd0, 16'd0, 16'd0);
      send_coord(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_coord(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_coord(16'd0, 16'd0, 16'd1, 16'd1);

      // Rank three: sum right at the top of the range, then one past it
      apply_config(3'd3, {16'd9, 16'd2, 16'hFFFF, 16'd7}, LAYOUT_RESET, 1'b0);
      send_coord(16'd32768, 16'd0, 16'd65535, 16'hFFFF);
      send_coord(16'd32768, 16'd1, 16'd65534, 16'd0);
      send_coord(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      // All four used dimensions sharing one position
      apply_config(3'd4, {16'd3, 16'd4, 16'd5, 16'd6}, 8'h00, 1'b0);
      send_coord(16'd1, 16'd2, 16'd3, 16'd4);

      // Used position not below the rank
      apply_config(3'd2, {16'd3, 16'd4, 16'd5, 16'd6}, 8'h06, 1'b0);
      send_coord(16'd1, 16'd2, 16'd3, 16'd4);

      // Rank zero acts as one; upper layout bits and sizes ignored
      apply_config(3'd0, {16'd0, 16'd0, 16'd0, 16'hFFFF}, 8'hFC, 1'b0);
      send_coord(16'hFFFF, 16'd1, 16'd2, 16'd3);

      // Rank above the limit, reversed layout, a zero size, unmapped writes
      apply_config(3'd7, {16'd3, 16'd5, 16'd0, 16'd11}, 8'h1B, 1'b1);
      send_coord(16'd1, 16'd1, 16'd1, 16'd1);
      send_coord(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      // Random register settings, each followed by a burst of coordinates
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         steady = (phase >= 10 && phase < 14);
         if ($urandom_range(99) < 85) begin
            r = rank_type'($urandom_range(1, 4));
         end else begin
            r = rank_type'($urandom_range(0, 3));
            if (r != 0) r = r + 3'd4;
         end
         used = (r == 0) ? 1 : (r > MAX_RANK) ? MAX_RANK : int'(r);
         for (d = 0; d < NUM_DIMS; d++) begin
            case ($urandom_range(9))
               5, 6:    sz[d] = size_type'($urandom_range(1, 65535));
               7:       sz[d] = 16'hFFFF;
               8:       sz[d] = 16'd1;
               9:       sz[d] = 16'd0;
               default: sz[d] = size_type'($urandom_range(1, 16));
            endcase
         end
         lay = ($urandom_range(99) < 85) ? make_layout(used) : layout_type'($urandom);
         apply_config(r, sz, lay, $urandom_range(3) == 0);
         n_items = $urandom_range(50, 98);
         for (j = 0; j < n_items; j++) begin
            wild = ($urandom_range(99) < 20);
            send_coord(pick_index(sz[0], wild), pick_index(sz[1], wild),
                       pick_index(sz[2], wild), pick_index(sz[3], wild));
         end
      end

      settle();
      $display("Covered %0d coordinates over %0d register settings, including reset values,",
               coord_count, settings_count);
      $display("rank clamping, zero sizes and unmapped writes: %0d wrapped, %0d rejected layouts.",
               wrapped_count, rejected_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS permuted_tensor_address_gen_top");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count, pending_count);
         $display("FAIL permuted_tensor_address_gen_top");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ptag_pkg.sv
rtl/ptag_csr.sv
rtl/ptag_stride.sv
rtl/ptag_accum.sv
rtl/permuted_tensor_address_gen_top.sv
rtl/ptag_checker.sv
test/ptag_offset_checker.sv
test/permuted_tensor_address_gen_top_test.sv
